### sv/s256_pkg.sv
// Package: SHA-256 constants, types and round functions for the byte stream hasher.
package s256_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned CountWidth = 61;
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueueAw = 2;

   typedef logic [31:0] word_type;

   // one classified item as handed from front to back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last_item;
   } item_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_number;
      logic        last_word;
   } result_type;

   localparam word_type RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic word_type ror32(input word_type x, input int unsigned n);
      ror32 = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_s0(input word_type a);
      big_s0 = ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
   endfunction

   function automatic word_type big_s1(input word_type e);
      big_s1 = ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
   endfunction

   function automatic word_type small_s0(input word_type x);
      small_s0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_s1(input word_type x);
      small_s1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
   endfunction

endpackage

### sv/s256_stream_if.sv
// Interface: valid/ready stream channel carrying a generic payload.
interface s256_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### sv/sha256_byte_stream_hasher.sv
// Top level: SHA-256 hasher over a byte stream, front queue plus compression back end.
// Usage:
//   req channel carries one byte item per transfer (data_byte, has_byte, last_item).
//   rsp channel returns eight digest words after an item with last_item set,
//   word 0 first, last_word high on word 7.
//   A byte that fills a 64-byte block is taken, then the back end loads 16 schedule
//   words, runs 64 rounds and adds the result into the hash; other bytes are only
//   taken. A closing item adds a pad sweep from the fill position to the end of the
//   block (the whole block for a second length block), one or two block compressions,
//   then eight digest words, one per word transfer.
//   The single round unit, which runs one round per cycle, sets the sustained rate.
//   A four-entry queue lets the front keep taking bytes while a block compresses.
//   Items with neither a byte nor an end mark are dropped on transfer.
//   Reset (synchronous, active high) restores the initial hash values, zeroes
//   the byte count and empties the queue.
//   When the receiver stalls, the current digest word holds and the back end
//   waits; the front keeps filling the queue until it is full.
module sha256_byte_stream_hasher (
   input logic          clock,
   input logic          reset,
   s256_stream_if.sink   req,
   s256_stream_if.source rsp
);
   import s256_pkg::*;

   logic       q_valid, q_ready;
   item_type   q_item;

   s256_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (req.ready),
      .in_item  (req.payload),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_item   (q_item)
   );

   s256_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_res   (rsp.payload)
   );

   // last word marker only on word seven
   a_last_word: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.payload.last_word == (rsp.payload.word_number == 3'd7)))
      else $error("last_word mismatch");

   // words advance by one after each result transfer but the last
   a_word_step: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && !rsp.payload.last_word) |=>
      (rsp.valid && rsp.payload.word_number == $past(rsp.payload.word_number) + 3'd1))
      else $error("digest word order broken");

   // no queue pop while results are pending
   a_no_pop_emit: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !q_ready)
      else $error("back end took an item during output");
endmodule

### sv/s256_front.sv
// Front end: accept byte items and queue them for the compression engine.
module s256_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  s256_pkg::item_type  in_item,
   output logic                q_valid,
   input  logic                q_ready,
   output s256_pkg::item_type  q_item
);
   import s256_pkg::*;

   item_type          mem [QueueDepth];
   logic [QueueAw-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QueueAw:0]   count_ff, count_in;
   logic               push, pop;

   // drop idle items (no byte, no end) at the door
   assign in_ready = (count_ff != (QueueAw+1)'(QueueDepth));
   assign push     = in_valid && in_ready && (in_item.has_byte || in_item.last_item);
   assign q_valid  = (count_ff != '0);
   assign pop      = q_valid && q_ready;
   assign q_item   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
   end

   // write queue entry on transfer
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

### sv/s256_back.sv
// Back end: block buffer, padding, message schedule, 64-round compression and digest output.
module s256_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  s256_pkg::item_type   q_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output s256_pkg::result_type out_res
);
   import s256_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LOAD  = 6'b000010,
      ST_ROUND = 6'b000100,
      ST_ADD   = 6'b001000,
      ST_PAD   = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   word_type  h_ff [8];
   word_type  v_ff [8];
   word_type  w_ff [16];          // rolling schedule window
   word_type  buf_ff [BlockBytes/4]; // block buffer, four bytes per entry, big-endian
   logic [CountWidth-1:0] count_ff;
   logic [5:0] round_ff;          // round / byte index
   logic       final_ff;          // this block is the length block
   logic       pend_ff;           // a pad-end still owed after this block
   logic [2:0] word_ff;
   logic [5:0] pos;
   logic [CountWidth+2:0] bits;
   word_type   t1, t2, w_new, w_cur;
   logic [7:0] pad_byte;

   assign pos  = count_ff[5:0];
   assign bits = {count_ff, 3'b000};
   assign w_cur = w_ff[0];
   assign t1 = v_ff[7] + big_s1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + RoundK[round_ff] + w_cur;
   assign t2 = big_s0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2])
             ^ (v_ff[1] & v_ff[2]));
   assign w_new = w_ff[0] + small_s0(w_ff[1]) + w_ff[9] + small_s1(w_ff[14]);

   assign q_ready   = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_EMIT);
   assign out_res.digest_word = h_ff[word_ff];
   assign out_res.word_number = word_ff;
   assign out_res.last_word   = (word_ff == 3'd7);

   // padding byte at buffer index round_ff while the pad pass runs;
   // the end mark goes in the first pad pass only
   always_comb begin
      if (round_ff == pos && (pend_ff || pos < 6'd56)) begin
         pad_byte = 8'h80;
      end else if (final_ff && round_ff >= 6'd56) begin
         pad_byte = bits[8*(63-round_ff) +: 8];
      end else begin
         pad_byte = 8'h00;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (q_valid) begin
            if (q_item.has_byte && pos == 6'd63) state_in = ST_LOAD;
            else if (q_item.last_item) state_in = ST_PAD;
         end
         ST_PAD:  if (round_ff == 6'd63) state_in = ST_LOAD;
         ST_LOAD: if (round_ff == 6'd15) state_in = ST_ROUND;
         ST_ROUND: if (round_ff == 6'd63) state_in = ST_ADD;
         ST_ADD: begin
            if (pend_ff) state_in = ST_PAD;
            else if (final_ff) state_in = ST_EMIT;
            else state_in = ST_IDLE;
         end
         ST_EMIT: if (out_ready && word_ff == 3'd7) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // buffer writes: bytes from the queue and the pad sweep
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && q_valid && q_item.has_byte) begin
         buf_ff[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= q_item.data_byte;
      end else if (state_ff == ST_PAD && round_ff >= pos) begin
         buf_ff[round_ff[5:2]][{~round_ff[1:0], 3'b000} +: 8] <= pad_byte;
      end else if (state_ff == ST_PAD && final_ff) begin
         buf_ff[round_ff[5:2]][{~round_ff[1:0], 3'b000} +: 8] <= pad_byte;
      end
   end

   // schedule window and working variables
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= buf_ff[round_ff[3:0]];
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (state_ff == ST_ROUND) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         round_ff <= '0;
         final_ff <= 1'b0;
         pend_ff  <= 1'b0;
         word_ff  <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= InitHash[i];
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               round_ff <= '0;
               if (q_valid) begin
                  logic [CountWidth-1:0] nc;
                  nc = count_ff + CountWidth'(q_item.has_byte);
                  count_ff <= nc;
                  if (q_item.last_item) begin
                     // two blocks when 0x80 does not leave room for the length
                     pend_ff  <= (nc[5:0] >= 6'd56);
                     final_ff <= (nc[5:0] < 6'd56);
                     round_ff <= q_item.has_byte && pos == 6'd63 ? 6'd0 : nc[5:0];
                     // a closing byte that fills the block: compress, then pad
                     if (q_item.has_byte && pos == 6'd63) begin
                        pend_ff <= 1'b1;
                        final_ff <= 1'b0;
                     end
                  end
               end
            end
            ST_PAD:  round_ff <= round_ff + 6'd1;
            ST_LOAD: round_ff <= (round_ff == 6'd15) ? 6'd0 : round_ff + 6'd1;
            ST_ROUND: round_ff <= round_ff + 6'd1;
            ST_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               round_ff <= '0;
               word_ff  <= '0;
               if (pend_ff) begin
                  pend_ff  <= 1'b0;
                  final_ff <= 1'b1;
               end
            end
            ST_EMIT: if (out_ready) begin
               word_ff <= word_ff + 3'd1;
               if (word_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) h_ff[i] <= InitHash[i];
                  count_ff <= '0;
                  final_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end
endmodule
